// ===== src/swmm_pkg.sv =====
package swmm_pkg;

  localparam int VALUE_BITS = 24;
  localparam int TIME_BITS = 32;
  localparam int CFG_BITS = 7;
  localparam logic [CFG_BITS-1:0] CFG_RESET = 7'd8;
  localparam int DEF_MAX_WINDOW = 64;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] sample_value;
    logic [TIME_BITS-1:0]         sample_time;
    logic                         series_start;
  } in_word_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]         window_first_time;
    logic [TIME_BITS-1:0]         window_last_time;
    logic signed [VALUE_BITS-1:0] window_mean;
    logic signed [VALUE_BITS-1:0] lowest_value;
    logic [TIME_BITS-1:0]         lowest_time;
    logic signed [VALUE_BITS-1:0] highest_value;
    logic [TIME_BITS-1:0]         highest_time;
  } out_word_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RDOLD = 7'b0000010,
    S_SUB   = 7'b0000100,
    S_WR    = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_OUT   = 7'b1000000
  } seq_state_t;

endpackage

// ===== src/swmm_ram.sv =====
module swmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/swmm_div.sv =====
module swmm_div #(
  parameter int NUM_W = 31,
  parameter int DEN_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic [NUM_W-1:0] quotient,
  output logic             done
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // One quotient bit per cycle, most significant first.
  always_comb begin
    trial = {rem_r, quo_r[NUM_W-1]};
    diff = trial - {1'b0, den_r};
    ge = (trial >= {1'b0, den_r});
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      den_nxt = divisor;
      cnt_nxt = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign quotient = quo_r;
  assign done = done_r;

endmodule

// ===== src/sliding_window_min_max_mean.sv =====
// Channel  Direction  Handshake              Carries
// in       input      in_valid / in_ready    in_word_t: value, timestamp, series start
// out      output     out_valid / out_ready  out_word_t: times, mean, lowest, highest
// cfg      input      cfg_valid / cfg_ready  window length, 7 bits
//
// A word that gives no result passes only S_RDOLD and S_WR; one that gives a result also
// passes S_SUB once the window is full, then S_SCAN, a scan of the sample memory through
// its single read port, and S_DIV, the bit-serial divider, before S_OUT.
// Reset is synchronous and needs no clearing pass: the window starts empty.
// The next word is taken while a result waits in the output register; the sequencer
// stalls only when a new result is ready and the previous one has not been taken.
module sliding_window_min_max_mean #(
  parameter int MAX_WINDOW = swmm_pkg::DEF_MAX_WINDOW
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  swmm_pkg::in_word_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output swmm_pkg::out_word_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [swmm_pkg::CFG_BITS-1:0]       cfg_data
);

  import swmm_pkg::*;

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LW = $clog2(MAX_WINDOW + 1);
  localparam int IW = AW + 2;
  localparam int SUM_W = VALUE_BITS + LW;
  localparam int MEM_W = VALUE_BITS + TIME_BITS;

  function automatic logic [AW-1:0] ring_back(input logic [AW-1:0] pos,
                                              input logic [LW-1:0] len);
    logic [IW-1:0] t;
    begin
      t = IW'(pos) + IW'(MAX_WINDOW) - IW'(len);
      if (t >= IW'(MAX_WINDOW)) begin
        t = t - IW'(MAX_WINDOW);
      end
      ring_back = t[AW-1:0];
    end
  endfunction

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] pos);
    begin
      if (IW'(pos) == IW'(MAX_WINDOW - 1)) begin
        ring_inc = '0;
      end else begin
        ring_inc = pos + 1'b1;
      end
    end
  endfunction

  seq_state_t state_r, state_nxt;
  logic [CFG_BITS-1:0] cfg_r, cfg_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [LW-1:0] fill_r, fill_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt;
  logic pend_r, pend_nxt;
  logic first_r, first_nxt;
  logic out_valid_r, out_valid_nxt;

  in_word_t item_r, item_nxt;
  logic signed [VALUE_BITS-1:0] lo_val_r, lo_val_nxt, hi_val_r, hi_val_nxt;
  logic [TIME_BITS-1:0] lo_time_r, lo_time_nxt, hi_time_r, hi_time_nxt;
  logic [TIME_BITS-1:0] first_time_r, first_time_nxt;
  logic signed [VALUE_BITS-1:0] mean_r, mean_nxt;
  out_word_t out_r, out_nxt;

  logic [LW-1:0] len_w;
  logic in_acc;
  logic cfg_acc;
  logic mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [MEM_W-1:0] mem_wdata, mem_rdata;
  logic signed [VALUE_BITS-1:0] rd_val;
  logic [TIME_BITS-1:0] rd_time;
  logic div_start, div_done;
  logic [SUM_W-1:0] div_mag, div_quo, mean_full;

  always_comb begin
    if (cfg_r == '0) begin
      len_w = LW'(1);
    end else if (32'(cfg_r) > 32'(MAX_WINDOW)) begin
      len_w = LW'(MAX_WINDOW);
    end else begin
      len_w = LW'(cfg_r);
    end
  end

  assign in_ready = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state_r == S_IDLE);
  assign in_acc = in_valid && in_ready;
  assign cfg_acc = cfg_valid && cfg_ready;

  assign rd_val = mem_rdata[MEM_W-1 -: VALUE_BITS];
  assign rd_time = mem_rdata[TIME_BITS-1:0];
  assign div_mag = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign mean_full = sum_r[SUM_W-1] ? -div_quo : div_quo;

  always_comb begin
    state_nxt = state_r;
    cfg_nxt = cfg_r;
    head_nxt = head_r;
    fill_nxt = fill_r;
    sum_nxt = sum_r;
    ptr_nxt = ptr_r;
    cnt_nxt = cnt_r;
    pend_nxt = 1'b0;
    first_nxt = first_r;
    out_valid_nxt = out_valid_r && !out_ready;
    item_nxt = item_r;
    lo_val_nxt = lo_val_r;
    lo_time_nxt = lo_time_r;
    hi_val_nxt = hi_val_r;
    hi_time_nxt = hi_time_r;
    first_time_nxt = first_time_r;
    mean_nxt = mean_r;
    out_nxt = out_r;
    mem_we = 1'b0;
    mem_waddr = head_r;
    mem_wdata = {item_r.sample_value, item_r.sample_time};
    mem_raddr = ptr_r;
    div_start = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (cfg_acc) begin
          cfg_nxt = cfg_data;
          head_nxt = '0;
          fill_nxt = '0;
          sum_nxt = '0;
        end
        if (in_acc) begin
          item_nxt = in_data;
          if (in_data.series_start) begin
            head_nxt = '0;
            fill_nxt = '0;
            sum_nxt = '0;
          end
          state_nxt = S_RDOLD;
        end
      end
      S_RDOLD: begin
        mem_raddr = ring_back(head_r, len_w);
        state_nxt = (fill_r >= len_w) ? S_SUB : S_WR;
      end
      S_SUB: begin
        sum_nxt = sum_r - SUM_W'(rd_val);
        fill_nxt = len_w - 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        mem_we = 1'b1;
        sum_nxt = sum_r + SUM_W'(item_r.sample_value);
        head_nxt = ring_inc(head_r);
        fill_nxt = fill_r + 1'b1;
        if ((fill_r + 1'b1) < len_w) begin
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt = ring_back(ring_inc(head_r), len_w);
          cnt_nxt = len_w;
          first_nxt = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt_r != '0) begin
          ptr_nxt = ring_inc(ptr_r);
          cnt_nxt = cnt_r - 1'b1;
          pend_nxt = 1'b1;
        end
        if (pend_r) begin
          if (first_r) begin
            first_nxt = 1'b0;
            lo_val_nxt = rd_val;
            lo_time_nxt = rd_time;
            hi_val_nxt = rd_val;
            hi_time_nxt = rd_time;
            first_time_nxt = rd_time;
          end else begin
            if (rd_val < lo_val_r) begin
              lo_val_nxt = rd_val;
              lo_time_nxt = rd_time;
            end
            if (rd_val > hi_val_r) begin
              hi_val_nxt = rd_val;
              hi_time_nxt = rd_time;
            end
          end
          if (cnt_r == '0) begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          mean_nxt = mean_full[VALUE_BITS-1:0];
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.window_first_time = first_time_r;
          out_nxt.window_last_time = item_r.sample_time;
          out_nxt.window_mean = mean_r;
          out_nxt.lowest_value = lo_val_r;
          out_nxt.lowest_time = lo_time_r;
          out_nxt.highest_value = hi_val_r;
          out_nxt.highest_time = hi_time_r;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cfg_r <= CFG_RESET;
      head_r <= '0;
      fill_r <= '0;
      sum_r <= '0;
      ptr_r <= '0;
      cnt_r <= '0;
      pend_r <= 1'b0;
      first_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cfg_r <= cfg_nxt;
      head_r <= head_nxt;
      fill_r <= fill_nxt;
      sum_r <= sum_nxt;
      ptr_r <= ptr_nxt;
      cnt_r <= cnt_nxt;
      pend_r <= pend_nxt;
      first_r <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    lo_val_r <= lo_val_nxt;
    lo_time_r <= lo_time_nxt;
    hi_val_r <= hi_val_nxt;
    hi_time_r <= hi_time_nxt;
    first_time_r <= first_time_nxt;
    mean_r <= mean_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

  swmm_ram #(
    .WIDTH(MEM_W),
    .DEPTH(MAX_WINDOW)
  ) u_ring (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  swmm_div #(
    .NUM_W(SUM_W),
    .DEN_W(LW)
  ) u_div (
    .clk(clk),
    .rst_n(rst_n),
    .start(div_start),
    .dividend(div_mag),
    .divisor(len_w),
    .quotient(div_quo),
    .done(div_done)
  );

endmodule
